// ----- hw/rtl/q24_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: operation codes, widths, queue entry type.
// No dependencies.
`default_nettype none
package q24_pkg;
    localparam int DataW    = 32;
    localparam int FracBits = 8;
    localparam int DivW     = DataW + FracBits;
    localparam int DivCntW  = $clog2(DivW + 1);
    localparam int QDepth   = 4;
    localparam int QAw      = 2;

    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_MIN = 4'd4, OP_MAX = 4'd5, OP_GT = 4'd6, OP_LT = 4'd7,
        OP_GE = 4'd8, OP_LE = 4'd9, OP_EQ = 4'd10, OP_NE = 4'd11,
        OP_INC = 4'd12, OP_DEC = 4'd13, OP_TOINT = 4'd14, OP_FROMINT = 4'd15
    } op_t;

    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [DataW-1:0]  value;
        logic              cmp;
        logic              dz;
        logic signed [DataW-1:0] a;
        logic signed [DataW-1:0] b;
    } entry_t;
endpackage
`default_nettype wire

// ----- hw/rtl/q24_8_fixed_point_alu.sv -----
// Q24.8 fixed-point ALU. Non-divide kinds pass the queue, the product stage and
// the output register; a divide waits on the radix-2 divider, which produces one
// of 40 quotient bits a cycle. Throughput: one item a cycle for non-divide kinds
// unless the output stalls; a divide holds the back end until its quotient.
// Reset (rst_n, async, active low) empties the queue and all valid flags.
`default_nettype none
module q24_8_fixed_point_alu
    import q24_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [3:0]        kind,
    input  wire logic signed [DataW-1:0] operand_a,
    input  wire logic signed [DataW-1:0] operand_b,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [DataW-1:0] result_raw,
    output logic                   compare_true,
    output logic                   divide_by_zero
);
    logic   q_valid, q_pop;
    entry_t q_head;

    // Front: classify and queue each transfer.
    q24_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (in_valid),
        .stall     (in_stall),
        .kind      (kind),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head)
    );

    // Back: execute and hold the result until its transfer.
    q24_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_head         (q_head),
        .valid          (out_valid),
        .stall          (out_stall),
        .result_raw     (result_raw),
        .compare_true   (compare_true),
        .divide_by_zero (divide_by_zero)
    );
endmodule
`default_nettype wire

// ----- hw/rtl/q24_front.sv -----
// Front end: accepts items, evaluates simple kinds, classifies mul/div, and
// holds classified entries in a short queue. Depends on q24_pkg.
`default_nettype none
module q24_front
    import q24_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    output logic                   stall,
    input  wire logic [3:0]        kind,
    input  wire logic signed [DataW-1:0] operand_a,
    input  wire logic signed [DataW-1:0] operand_b,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output entry_t                 q_head
);
    entry_t            mem [QDepth];
    logic [QAw-1:0]    wr_reg, rd_reg;
    logic [QAw:0]      cnt_reg;
    entry_t            ent;
    logic              push;

    always_comb
    begin
        ent       = '0;
        ent.a     = operand_a;
        ent.b     = operand_b;
        ent.cls   = CLS_SIMPLE;
        case (op_t'(kind))
            OP_ADD:     ent.value = operand_a + operand_b;
            OP_SUB:     ent.value = operand_a - operand_b;
            OP_MUL:     ent.cls = CLS_MUL;
            OP_DIV:
            begin
                ent.cls = CLS_DIV;
                ent.dz  = (operand_b == '0);
            end
            OP_MIN:     ent.value = (operand_a < operand_b) ? operand_a : operand_b;
            OP_MAX:     ent.value = (operand_a > operand_b) ? operand_a : operand_b;
            OP_GT:      ent.cmp = operand_a > operand_b;
            OP_LT:      ent.cmp = operand_a < operand_b;
            OP_GE:      ent.cmp = operand_a >= operand_b;
            OP_LE:      ent.cmp = operand_a <= operand_b;
            OP_EQ:      ent.cmp = operand_a == operand_b;
            OP_NE:      ent.cmp = operand_a != operand_b;
            OP_INC:     ent.value = operand_a + DataW'(1);
            OP_DEC:     ent.value = operand_a - DataW'(1);
            OP_TOINT:   ent.value = operand_a >>> FracBits;
            OP_FROMINT: ent.value = operand_a << FracBits;
            default:    ent.value = '0;
        endcase
    end

    assign stall   = (cnt_reg == (QAw+1)'(QDepth));
    assign push    = valid && !stall;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= ent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAw+1)'(push) - (QAw+1)'(q_pop);
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/q24_div.sv -----
// Radix-2 restoring divider for the fixed-point divide, one quotient bit a cycle.
// Depends on q24_pkg.
`default_nettype none
module q24_div
    import q24_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic signed [DataW-1:0] a,
    input  wire logic signed [DataW-1:0] b,
    output logic                        busy,
    output logic                        done,
    output logic [DataW-1:0]            quot
);
    logic [DivW-1:0]  q_reg;
    logic [DivW:0]    r_reg;
    logic [DataW-1:0] d_reg;
    logic             neg_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DivW-1:0]  num_abs;
    logic [DivW:0]    r_sh, r_sub;
    logic [DivW-1:0]  q_fin;

    always_comb
    begin
        num_abs = a[DataW-1] ? DivW'(-{{FracBits{a[DataW-1]}}, a, {FracBits{1'b0}}} >> 0)
                             : {a, {FracBits{1'b0}}};
        r_sh    = {r_reg[DivW-1:0], q_reg[DivW-1]};
        r_sub   = r_sh - {{(DivW+1-DataW){1'b0}}, d_reg};
        q_fin   = neg_reg ? -q_reg : q_reg;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = q_fin[DataW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DivCntW'(DivW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DivCntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num_abs;
            r_reg   <= '0;
            d_reg   <= b[DataW-1] ? -b : b;
            neg_reg <= a[DataW-1] ^ b[DataW-1];
        end
        else if (busy_reg)
        begin
            if (!r_sub[DivW])
            begin
                r_reg <= r_sub;
                q_reg <= {q_reg[DivW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh;
                q_reg <= {q_reg[DivW-2:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/q24_back.sv -----
// Back end: executes queued entries (pipelined multiply, iterative divide) and
// drives the output register. Depends on q24_pkg and q24_div.
`default_nettype none
module q24_back
    import q24_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    output logic                   q_pop,
    input  entry_t                 q_head,
    output logic                   valid,
    input  wire logic              stall,
    output logic signed [DataW-1:0] result_raw,
    output logic                   compare_true,
    output logic                   divide_by_zero
);
    // Pipeline: stage 1 holds the product, stage 2 the output register.
    logic                     s1_v_reg;
    entry_t                   s1_reg;
    logic signed [2*DataW-1:0] prod_reg;
    logic                     o_v_reg;
    logic [DataW-1:0]         o_res_reg;
    logic                     o_cmp_reg, o_dz_reg;
    logic                     div_start, div_busy, div_done;
    logic [DataW-1:0]         div_q;
    logic                     div_wait_reg;
    logic                     adv, o_free;
    logic signed [2*DataW-1:0] prod_sh;

    assign o_free = !o_v_reg || !stall;
    // Advance stage 1 into output when output frees; hold while a divide runs.
    assign adv = o_free && !div_wait_reg && !div_busy;
    assign q_pop = q_valid && adv && (!s1_v_reg || s1_reg.cls != CLS_DIV || s1_reg.dz);
    assign div_start = q_pop && q_head.cls == CLS_DIV && !q_head.dz;

    q24_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (q_head.a),
        .b     (q_head.b),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    assign prod_sh = prod_reg >>> FracBits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            o_v_reg      <= 1'b0;
            div_wait_reg <= 1'b0;
        end
        else
        begin
            if (o_v_reg && !stall)
            begin
                o_v_reg <= 1'b0;
            end
            if (div_done)
            begin
                div_wait_reg <= 1'b1;
            end
            if (div_wait_reg && o_free)
            begin
                o_v_reg      <= 1'b1;
                div_wait_reg <= 1'b0;
                s1_v_reg     <= 1'b0;
            end
            else if (adv)
            begin
                if (s1_v_reg && !(s1_reg.cls == CLS_DIV && !s1_reg.dz))
                begin
                    o_v_reg <= 1'b1;
                end
                s1_v_reg <= q_pop ? 1'b1 : (s1_v_reg && s1_reg.cls == CLS_DIV && !s1_reg.dz);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_reg   <= q_head;
            prod_reg <= q_head.a * q_head.b;
        end
        if (div_wait_reg && o_free)
        begin
            o_res_reg <= div_q;
            o_cmp_reg <= 1'b0;
            o_dz_reg  <= 1'b0;
        end
        else if (adv && s1_v_reg)
        begin
            o_cmp_reg <= s1_reg.cmp;
            o_dz_reg  <= s1_reg.dz;
            case (s1_reg.cls)
                CLS_MUL: o_res_reg <= prod_sh[DataW-1:0];
                CLS_DIV: o_res_reg <= '0;
                default: o_res_reg <= s1_reg.value;
            endcase
        end
    end

    assign valid          = o_v_reg;
    assign result_raw     = o_res_reg;
    assign compare_true   = o_cmp_reg;
    assign divide_by_zero = o_dz_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/q24_checker.sv -----
// Port-level checker for the Q24.8 ALU, bound to the top level.
// Depends on q24_pkg.
`default_nettype none
module q24_checker
    import q24_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic signed [DataW-1:0] result_raw,
    input wire logic compare_true,
    input wire logic divide_by_zero
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_raw))
        else $error("stalled result changed");
    a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_true |-> result_raw == '0)
        else $error("compare with nonzero result");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> result_raw == '0 && !compare_true)
        else $error("divide by zero with nonzero result");
endmodule

bind q24_8_fixed_point_alu q24_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_raw     (result_raw),
    .compare_true   (compare_true),
    .divide_by_zero (divide_by_zero)
);
`default_nettype wire

// ----- tb/tb_q24_8_fixed_point_alu.sv -----
// Self-checking testbench for the Q24.8 fixed-point ALU: directed corner cases, then random
// bursts with random stalls on the result side. Depends on q24_pkg and q24_8_fixed_point_alu.
`timescale 1ns / 100ps
`default_nettype none

class alu_scoreboard;
    logic signed [31:0] want_raw[$];
    bit want_cmp[$];
    bit want_dz[$];
    int mismatches;

    // Compute the expected result of one transfer and queue it.
    function void note_input(q24_pkg::op_t op, logic signed [31:0] a, logic signed [31:0] b);
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] prod;
        logic signed [31:0] res;
        bit cmp;
        bit dz;
        wa = a;
        wb = b;
        res = '0;
        cmp = 0;
        dz = 0;
        case (op)
            q24_pkg::OP_ADD: res = a + b;
            q24_pkg::OP_SUB: res = a - b;
            q24_pkg::OP_MUL:
            begin
                prod = wa * wb;
                prod = prod >>> q24_pkg::FracBits;
                res = prod[31:0];
            end
            q24_pkg::OP_DIV:
            begin
                if (b == 0)
                    dz = 1;
                else
                begin
                    // SV signed divide truncates toward zero
                    prod = (wa <<< q24_pkg::FracBits) / wb;
                    res = prod[31:0];
                end
            end
            q24_pkg::OP_MIN: res = (a < b) ? a : b;
            q24_pkg::OP_MAX: res = (a > b) ? a : b;
            q24_pkg::OP_GT: cmp = a > b;
            q24_pkg::OP_LT: cmp = a < b;
            q24_pkg::OP_GE: cmp = a >= b;
            q24_pkg::OP_LE: cmp = a <= b;
            q24_pkg::OP_EQ: cmp = a == b;
            q24_pkg::OP_NE: cmp = a != b;
            q24_pkg::OP_INC: res = a + 1;
            q24_pkg::OP_DEC: res = a - 1;
            q24_pkg::OP_TOINT: res = a >>> q24_pkg::FracBits;
            default: res = a << q24_pkg::FracBits;
        endcase
        want_raw.push_back(res);
        want_cmp.push_back(cmp);
        want_dz.push_back(dz);
    endfunction

    // Compare one result transfer against the oldest expectation.
    function void check_result(logic signed [31:0] raw, logic cmp, logic dz);
        logic signed [31:0] er;
        bit ec;
        bit ed;
        if (want_raw.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result raw=%h cmp=%b dz=%b", raw, cmp, dz);
            return;
        end
        er = want_raw.pop_front();
        ec = want_cmp.pop_front();
        ed = want_dz.pop_front();
        if (raw !== er || cmp !== ec || dz !== ed)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected raw=%h cmp=%b dz=%b, got raw=%h cmp=%b dz=%b",
                         er, ec, ed, raw, cmp, dz);
        end
    endfunction

    function int pending();
        return want_raw.size();
    endfunction
endclass

module tb_q24_8_fixed_point_alu;
    import q24_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [3:0] kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] result_raw;
    logic compare_true;
    logic divide_by_zero;

    alu_scoreboard sb;
    bit stall_quiet;   // stretch with no output stalls

    q24_8_fixed_point_alu u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_raw(result_raw), .compare_true(compare_true),
        .divide_by_zero(divide_by_zero)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Hard limit: even an all-divide run with stalls fits easily.
    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Sample and check results at the rising edge.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(result_raw, compare_true, divide_by_zero);

    // Receiver stall pattern: alternate quiet stretches with random stalls.
    initial
    begin
        int left;
        out_stall = 0;
        left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                stall_quiet = !stall_quiet;
                left = $urandom_range(5, 60);
            end
            left--;
            out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 99) < 40);
        end
    end

    // Present one item and hold it until the transfer happens.
    task automatic send_item(op_t op, logic signed [31:0] a, logic signed [31:0] b);
        in_valid <= 1'b1;
        kind <= op;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(op, a, b);
        @(negedge clk);
    endtask

    // Drop valid for a random gap.
    task automatic idle_gap(int cycles);
        in_valid <= 1'b0;
        kind <= 4'($urandom());
        operand_a <= $urandom();
        operand_b <= $urandom();
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 2047)) - 1024;
            4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic signed [31:0] corners[6];
        int burst;
        int wait_cycles;
        sb = new();
        rst_n = 0;
        in_valid = 0;
        kind = '0;
        operand_a = '0;
        operand_b = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: every kind on extreme operands, plus divide by zero and min/max ties.
        corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd256, -32'sd256};
        for (int k = 0; k < 16; k++)
            send_item(op_t'(k), corners[k % 6], corners[(k + 1) % 6]);
        send_item(OP_DIV, 32'sd256, 32'sd0);
        send_item(OP_DIV, 32'sh8000_0000, -32'sd1);
        send_item(OP_DIV, -32'sd7, 32'sd2);
        send_item(OP_MUL, 32'sh8000_0000, 32'sh8000_0000);
        send_item(OP_MIN, 32'sd5, 32'sd5);
        send_item(OP_MAX, -32'sd5, -32'sd5);
        send_item(OP_EQ, 32'sd9, 32'sd9);
        send_item(OP_TOINT, -32'sd1, 32'sd0);
        send_item(OP_DEC, 32'sh8000_0000, 32'sd0);

        // Random bursts with gaps between them.
        for (int n = 0; n < 1150; )
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst; i++, n++)
                send_item(op_t'($urandom_range(0, 15)), pick_operand(),
                          ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_operand());
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 12));
        end
        idle_gap(1);

        // Drain, then allow extra cycles for anything stray.
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire
